### rtl/core/tsl_pkg.sv
// Shared types and constants of the twist speed limiter.
`timescale 1ns / 1ps
package tsl_pkg;

    localparam int AXIS_COUNT = 6;
    localparam int LIN_AXES   = 3;
    localparam int COMP_W     = 32;
    localparam int LIM_W      = 31;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 34;
    localparam int QUO_W      = 31;
    localparam int IDX_W      = 2;

    localparam logic [5:0]       MASK_RESET = 6'd63;
    localparam logic [LIM_W-1:0] LIM_RESET  = 31'd65536;

    typedef enum logic [IDX_W-1:0] {
        REG_AXIS_MASK = 2'd0,
        REG_MAX_LIN   = 2'd1,
        REG_MAX_ANG   = 2'd2
    } reg_idx_t;

    // Item inside the square-root pipe: part 0 linear, part 1 angular.
    typedef struct packed {
        logic [AXIS_COUNT-1:0][COMP_W-1:0] comp;
        logic [1:0]                        nlin;
        logic [1:0]                        nang;
        logic [LIM_W-1:0]                  lim_lin;
        logic [LIM_W-1:0]                  lim_ang;
        logic                              lc;
        logic                              ac;
        logic [1:0][SUM_W-1:0]             x;
        logic [1:0][REM_W-1:0]             rem;
        logic [1:0][ROOT_W-1:0]            root;
    } sq_t;

    // Item inside the divider pipe, one lane per component.
    typedef struct packed {
        logic [AXIS_COUNT-1:0][COMP_W-1:0] comp;
        logic [AXIS_COUNT-1:0]             scale;
        logic                              lc;
        logic                              ac;
        logic [AXIS_COUNT-1:0][ROOT_W-1:0] norm;
        logic [AXIS_COUNT-1:0][ROOT_W-1:0] rem;
        logic [AXIS_COUNT-1:0][QUO_W-1:0]  plow;
        logic [AXIS_COUNT-1:0][QUO_W-1:0]  quo;
    } dv_t;

    function automatic logic [COMP_W-1:0] mag_of(input logic [COMP_W-1:0] c);
        return c[COMP_W-1] ? (~c + 1'b1) : c;
    endfunction

endpackage

### rtl/core/tsl_if.sv
// Channel interfaces: twist in, limited twist out, register writes.
`timescale 1ns / 1ps
interface tsl_twist_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] comp0;
    logic signed [31:0] comp1;
    logic signed [31:0] comp2;
    logic signed [31:0] comp3;
    logic signed [31:0] comp4;
    logic signed [31:0] comp5;
    modport source (output valid, comp0, comp1, comp2, comp3, comp4, comp5, input ready);
    modport sink (input valid, comp0, comp1, comp2, comp3, comp4, comp5, output ready);
endinterface

interface tsl_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out0;
    logic signed [31:0] out1;
    logic signed [31:0] out2;
    logic signed [31:0] out3;
    logic signed [31:0] out4;
    logic signed [31:0] out5;
    logic               linear_clamped;
    logic               angular_clamped;
    modport source (output valid, out0, out1, out2, out3, out4, out5,
                    linear_clamped, angular_clamped, input ready);
    modport sink (input valid, out0, out1, out2, out3, out4, out5,
                  linear_clamped, angular_clamped, output ready);
endinterface

interface tsl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/tsl_front.sv
// Front stages: capture, squares, per-part sums and clamp test.
`timescale 1ns / 1ps
module tsl_front
    import tsl_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [AXIS_COUNT-1:0][COMP_W-1:0] in_comp,
    input  logic [5:0]                        mask,
    input  logic [LIM_W-1:0]                  lim_lin,
    input  logic [LIM_W-1:0]                  lim_ang,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sq_t                               out_data
);

    logic                              v1_reg, v2_reg, v3_reg, v4_reg;
    logic                              rdy1, rdy2, rdy3, rdy4;
    logic [AXIS_COUNT-1:0][COMP_W-1:0] comp1_reg, comp2_reg, comp3_reg;
    logic [1:0]                        nlin1_reg, nlin2_reg, nlin3_reg;
    logic [1:0]                        nang1_reg, nang2_reg, nang3_reg;
    logic [LIM_W-1:0]                  ll1_reg, ll2_reg, ll3_reg;
    logic [LIM_W-1:0]                  la1_reg, la2_reg, la3_reg;
    logic [AXIS_COUNT-1:0][SUM_W-1:0]  sqr2_reg;
    logic [1:0][2*LIM_W-1:0]           limsq2_reg, limsq3_reg;
    logic [1:0][SUM_W-1:0]             sum3_reg, sum_next;
    logic [1:0]                        nlin_in, nang_in;
    logic [2:0]                        lin_end, ang_end;
    sq_t                               out_reg, out_next;

    assign rdy4     = ~v4_reg | out_ready;
    assign rdy3     = ~v3_reg | rdy4;
    assign rdy2     = ~v2_reg | rdy3;
    assign rdy1     = ~v1_reg | rdy2;
    assign in_ready = rdy1;

    assign nlin_in = 2'({1'b0, mask[0]} + {1'b0, mask[1]} + {1'b0, mask[2]});
    assign nang_in = 2'({1'b0, mask[3]} + {1'b0, mask[4]} + {1'b0, mask[5]});

    assign lin_end = {1'b0, nlin2_reg};
    assign ang_end = {1'b0, nlin2_reg} + {1'b0, nang2_reg};

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < AXIS_COUNT; i++)
        begin
            if (3'(i) < lin_end)
                sum_next[0] = sum_next[0] + sqr2_reg[i];
            else if (3'(i) < ang_end)
                sum_next[1] = sum_next[1] + sqr2_reg[i];
        end
    end

    always_comb
    begin
        out_next         = '0;
        out_next.comp    = comp3_reg;
        out_next.nlin    = nlin3_reg;
        out_next.nang    = nang3_reg;
        out_next.lim_lin = ll3_reg;
        out_next.lim_ang = la3_reg;
        out_next.lc      = sum3_reg[0] > {2'b00, limsq3_reg[0]};
        out_next.ac      = sum3_reg[1] > {2'b00, limsq3_reg[1]};
        out_next.x       = sum3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            comp1_reg <= in_comp;
            nlin1_reg <= nlin_in;
            nang1_reg <= nang_in;
            ll1_reg   <= lim_lin;
            la1_reg   <= lim_ang;
        end
        if (rdy2 && v1_reg)
        begin
            for (int i = 0; i < AXIS_COUNT; i++)
                sqr2_reg[i] <= mag_of(comp1_reg[i]) * mag_of(comp1_reg[i]);
            limsq2_reg[0] <= ll1_reg * ll1_reg;
            limsq2_reg[1] <= la1_reg * la1_reg;
            comp2_reg     <= comp1_reg;
            nlin2_reg     <= nlin1_reg;
            nang2_reg     <= nang1_reg;
            ll2_reg       <= ll1_reg;
            la2_reg       <= la1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            sum3_reg   <= sum_next;
            limsq3_reg <= limsq2_reg;
            comp3_reg  <= comp2_reg;
            nlin3_reg  <= nlin2_reg;
            nang3_reg  <= nang2_reg;
            ll3_reg    <= ll2_reg;
            la3_reg    <= la2_reg;
        end
        if (rdy4 && v3_reg)
            out_reg <= out_next;
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

    // a clamped part cannot have a zero sum of squares
    a_clamp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && out_reg.lc |-> out_reg.x[0] != '0)
        else $error("linear clamp with zero sum");

endmodule

### rtl/core/tsl_sqrt_step.sv
// One digit stage of the two-part integer square root.
`timescale 1ns / 1ps
module tsl_sqrt_step
    import tsl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sq_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output sq_t  out_data
);

    logic valid_reg;
    sq_t  data_reg, data_next;
    logic [REM_W-1:0] rem2, trial;

    assign in_ready = ~valid_reg | out_ready;

    always_comb
    begin
        data_next = in_data;
        rem2      = '0;
        trial     = '0;
        for (int p = 0; p < 2; p++)
        begin
            rem2  = {in_data.rem[p][REM_W-3:0], in_data.x[p][SUM_W-1 -: 2]};
            trial = {in_data.root[p], 2'b01};
            data_next.x[p] = {in_data.x[p][SUM_W-3:0], 2'b00};
            if (rem2 >= trial)
            begin
                data_next.rem[p]  = rem2 - trial;
                data_next.root[p] = {in_data.root[p][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                data_next.rem[p]  = rem2;
                data_next.root[p] = {in_data.root[p][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> data_reg.rem[0] <= {1'b0, data_reg.root[0], 1'b0})
        else $error("square root remainder out of range");

endmodule

### rtl/core/tsl_prod.sv
// Lane routing and limit times magnitude product ahead of the divider.
`timescale 1ns / 1ps
module tsl_prod
    import tsl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sq_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output dv_t  out_data
);

    logic valid_reg;
    dv_t  data_reg, data_next;
    logic [2:0] lin_end, ang_end;
    logic [LIM_W-1:0] lim;
    logic [LIM_W+COMP_W-1:0] prod;

    assign in_ready = ~valid_reg | out_ready;
    assign lin_end  = {1'b0, in_data.nlin};
    assign ang_end  = {1'b0, in_data.nlin} + {1'b0, in_data.nang};

    always_comb
    begin
        data_next      = '0;
        data_next.comp = in_data.comp;
        data_next.lc   = in_data.lc;
        data_next.ac   = in_data.ac;
        lim            = '0;
        prod           = '0;
        for (int i = 0; i < AXIS_COUNT; i++)
        begin
            if (3'(i) < lin_end)
            begin
                lim                = in_data.lim_lin;
                data_next.norm[i]  = in_data.root[0];
                data_next.scale[i] = in_data.lc;
            end
            else
            begin
                lim                = in_data.lim_ang;
                data_next.norm[i]  = in_data.root[1];
                data_next.scale[i] = in_data.ac && (3'(i) < ang_end);
            end
            prod              = lim * mag_of(in_data.comp[i]);
            data_next.rem[i]  = prod[LIM_W+COMP_W-1 -: ROOT_W];
            data_next.plow[i] = prod[QUO_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/tsl_div_step.sv
// One quotient-bit stage of the six-lane restoring divider.
`timescale 1ns / 1ps
module tsl_div_step
    import tsl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  dv_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output dv_t  out_data
);

    logic valid_reg;
    dv_t  data_reg, data_next;
    logic [ROOT_W:0] r2;

    assign in_ready = ~valid_reg | out_ready;

    always_comb
    begin
        data_next = in_data;
        r2        = '0;
        for (int i = 0; i < AXIS_COUNT; i++)
        begin
            r2 = {in_data.rem[i], in_data.plow[i][QUO_W-1]};
            data_next.plow[i] = {in_data.plow[i][QUO_W-2:0], 1'b0};
            if (r2 >= {1'b0, in_data.norm[i]})
            begin
                data_next.rem[i] = ROOT_W'(r2 - {1'b0, in_data.norm[i]});
                data_next.quo[i] = {in_data.quo[i][QUO_W-2:0], 1'b1};
            end
            else
            begin
                data_next.rem[i] = r2[ROOT_W-1:0];
                data_next.quo[i] = {in_data.quo[i][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // a scaled lane 0 keeps the partial remainder below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.scale[0] |-> data_reg.rem[0] < data_reg.norm[0])
        else $error("divider remainder not below norm");

endmodule

### rtl/core/twist_speed_limiter.sv
// Twist speed limiter top level: config registers, pipeline chain, result register.
//
// Usage: six signed Q16.16 twist components enter on the twist channel; the
// result channel returns the six limited components with the linear and
// angular clamp flags, one result beat per twist beat, in order.
// The axis mask picks how many leading components form the linear part and
// how many following ones form the angular part; each part whose Euclidean
// norm exceeds its limit is scaled to that limit.
// Registers are written on the cfg channel (always ready); the user must write
// them only while no twist is in flight, which the block does not enforce:
// index 0 axis mask, 1 linear limit, 2 angular limit. The pipe is 4 front
// stages, 32 square-root digit stages, 1 product stage, 31 divider stages and
// the output register. Throughput is one twist per cycle while the result is
// taken; the depth of the bit-per-stage root and divider sets the latency.
// Reset empties the pipe and loads mask 63 and both limits 1.0.
// When the receiver stalls, the result holds and the pipe keeps filling
// bubbles; twist.ready drops only once every stage holds a beat.
`timescale 1ns / 1ps
module twist_speed_limiter
    import tsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tsl_twist_if.sink   twist,
    tsl_result_if.source result,
    tsl_cfg_if.sink     cfg
);

    localparam int SQ_STAGES = ROOT_W;
    localparam int DV_STAGES = QUO_W;

    logic [5:0]       mask_reg;
    logic [LIM_W-1:0] lim_lin_reg, lim_ang_reg;

    logic [AXIS_COUNT-1:0][COMP_W-1:0] in_comp;

    logic sq_v [0:SQ_STAGES];
    logic sq_r [0:SQ_STAGES];
    sq_t  sq_d [0:SQ_STAGES];
    logic dv_v [0:DV_STAGES];
    logic dv_r [0:DV_STAGES];
    dv_t  dv_d [0:DV_STAGES];

    logic                              ov_reg;
    logic                              out_rdy;
    logic [AXIS_COUNT-1:0][COMP_W-1:0] out_reg, out_next;
    logic                              lc_reg, ac_reg;
    logic [COMP_W-1:0]                 qext;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= MASK_RESET;
            lim_lin_reg <= LIM_RESET;
            lim_ang_reg <= LIM_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_AXIS_MASK: mask_reg    <= cfg.data[5:0];
                REG_MAX_LIN:   lim_lin_reg <= cfg.data[LIM_W-1:0];
                REG_MAX_ANG:   lim_ang_reg <= cfg.data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_comp = {twist.comp5, twist.comp4, twist.comp3,
                      twist.comp2, twist.comp1, twist.comp0};

    tsl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (twist.valid),
        .in_ready  (twist.ready),
        .in_comp   (in_comp),
        .mask      (mask_reg),
        .lim_lin   (lim_lin_reg),
        .lim_ang   (lim_ang_reg),
        .out_valid (sq_v[0]),
        .out_ready (sq_r[0]),
        .out_data  (sq_d[0])
    );

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_sqrt
        tsl_sqrt_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[k]),
            .in_ready  (sq_r[k]),
            .in_data   (sq_d[k]),
            .out_valid (sq_v[k+1]),
            .out_ready (sq_r[k+1]),
            .out_data  (sq_d[k+1])
        );
    end

    tsl_prod u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_v[SQ_STAGES]),
        .in_ready  (sq_r[SQ_STAGES]),
        .in_data   (sq_d[SQ_STAGES]),
        .out_valid (dv_v[0]),
        .out_ready (dv_r[0]),
        .out_data  (dv_d[0])
    );

    for (genvar k = 0; k < DV_STAGES; k++)
    begin : g_div
        tsl_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_v[k]),
            .in_ready  (dv_r[k]),
            .in_data   (dv_d[k]),
            .out_valid (dv_v[k+1]),
            .out_ready (dv_r[k+1]),
            .out_data  (dv_d[k+1])
        );
    end

    assign out_rdy          = ~ov_reg | result.ready;
    assign dv_r[DV_STAGES]  = out_rdy;

    // scaled lanes take the sign of the input back; others pass through
    always_comb
    begin
        out_next = '0;
        qext     = '0;
        for (int i = 0; i < AXIS_COUNT; i++)
        begin
            qext = {1'b0, dv_d[DV_STAGES].quo[i]};
            if (!dv_d[DV_STAGES].scale[i])
                out_next[i] = dv_d[DV_STAGES].comp[i];
            else if (dv_d[DV_STAGES].comp[i][COMP_W-1])
                out_next[i] = ~qext + 1'b1;
            else
                out_next[i] = qext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (out_rdy)
            ov_reg <= dv_v[DV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && dv_v[DV_STAGES])
        begin
            out_reg <= out_next;
            lc_reg  <= dv_d[DV_STAGES].lc;
            ac_reg  <= dv_d[DV_STAGES].ac;
        end
    end

    assign result.valid           = ov_reg;
    assign result.out0            = out_reg[0];
    assign result.out1            = out_reg[1];
    assign result.out2            = out_reg[2];
    assign result.out3            = out_reg[3];
    assign result.out4            = out_reg[4];
    assign result.out5            = out_reg[5];
    assign result.linear_clamped  = lc_reg;
    assign result.angular_clamped = ac_reg;

endmodule
